// ===== rtl/core/vled_pkg.sv =====
// ----------------------------------------------------------------------------
// Velocity log ensemble deframer package
// Shared constants, item codes and types for the deframer front and back.
// ----------------------------------------------------------------------------
`default_nettype none

package vled_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_BUF_BYTES = 2048;
	localparam int DEF_MAX_TYPES = 16;

	// At most this many descriptors leave for one ensemble (4-bit type index).
	localparam int MAX_DESC = 16;

	// Ensemble layout.
	localparam logic [7:0]  SYNC_BYTE  = 8'h7F;
	localparam logic [15:0] MIN_LEN    = 16'd6;
	localparam int          COUNT_POS  = 5;
	localparam int          TABLE_BASE = 6;

	// Command codes of an input item.
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Kind codes of a result item.
	localparam logic KIND_DESC = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// One queued input item after classification.
	typedef struct packed {
		logic        is_read;
		logic [7:0]  rx_byte;
		logic [10:0] read_offset;
	} vled_item_t;

	// Parser phase.
	typedef enum logic [1:0] {
		PH_HUNT,
		PH_SYNC2,
		PH_LEN,
		PH_BODY
	} vled_phase_t;

	// Outcome of feeding one byte to the parser.
	typedef enum logic [1:0] {
		FD_MORE,
		FD_ACCEPT,
		FD_REJECT
	} vled_feed_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/vled_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Deframer command channel
// Valid/ready channel that carries byte pushes and stored-byte reads.
// ----------------------------------------------------------------------------
`default_nettype none

interface vled_cmd_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [7:0]  rx_byte;
	logic [10:0] read_offset;

	modport source (output valid, command, rx_byte, read_offset, input ready);
	modport sink   (input valid, command, rx_byte, read_offset, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vled_res_if.sv =====
// ----------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel that carries segment descriptors and read answers.
// ----------------------------------------------------------------------------
`default_nettype none

interface vled_res_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [3:0]  type_index;
	logic [10:0] seg_start;
	logic [10:0] seg_end;
	logic [7:0]  read_byte;
	logic        last;

	modport source (output valid, kind, type_index, seg_start, seg_end, read_byte, last,
		input ready);
	modport sink   (input valid, kind, type_index, seg_start, seg_end, read_byte, last,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/velocity_log_ensemble_deframer_top.sv =====
// ----------------------------------------------------------------------------
// Velocity log ensemble deframer
// Hunts 0x7F 0x7F ensembles in a byte stream, checks them and emits one
// segment descriptor per data type; also answers reads of the stored bytes.
// ----------------------------------------------------------------------------
//
//   Channel  Role    Payload                                   Moves
//   cmd      sink    command, rx_byte, read_offset             one item per push/read
//   res      source  kind, type_index, seg_start, seg_end,     descriptor or read answer
//                    read_byte, last
//
// In the back sequencer a push appends to the store, then runs one read and
// parse step per waiting byte and a final check. A rejected candidate adds a
// read and a write per moved byte and replays the moved bytes; an accepted
// ensemble adds table reads per descriptor through the single read port of
// the store. A read answer is read from the store and then registered.
// Reset clears all control state; the store holds no reset value.
// While the back stalls on a full result register the front queue keeps taking
// items until both entries fill; the result register holds its item until it is taken.
`default_nettype none

module velocity_log_ensemble_deframer_top #(
	parameter int BUF_BYTES = vled_pkg::DEF_BUF_BYTES,
	parameter int MAX_TYPES = vled_pkg::DEF_MAX_TYPES
) (
	input  logic       clk,
	input  logic       arst_n,
	vled_cmd_if.sink   cmd,
	vled_res_if.source res
);
	import vled_pkg::*;

	// Classified items travel from the front queue to the back sequencer.
	logic       q_valid;
	vled_item_t q_item;
	logic       q_pop;

	vled_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// The back owns the ensemble store, the parser with its replay logic,
	// descriptor emission and the result register.
	vled_back #(
		.BUF_BYTES (BUF_BYTES),
		.MAX_TYPES (MAX_TYPES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule

`default_nettype wire

// ===== rtl/core/vled_front.sv =====
// ----------------------------------------------------------------------------
// Deframer front
// Accepts command items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vled_front (
	input  logic                clk,
	input  logic                arst_n,
	vled_cmd_if.sink            cmd,
	output logic                q_valid,
	output vled_pkg::vled_item_t q_item,
	input  logic                q_pop
);
	import vled_pkg::*;

	vled_item_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign cmd.ready = (count_q != 2'd2);
	assign push      = cmd.valid & cmd.ready;
	assign q_valid   = (count_q != 2'd0);
	assign pop       = q_pop & q_valid;
	assign q_item    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q].is_read     <= (cmd.command == CMD_READ);
			slot_q[wr_ptr_q].rx_byte     <= cmd.rx_byte;
			slot_q[wr_ptr_q].read_offset <= cmd.read_offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/vled_back.sv =====
// ----------------------------------------------------------------------------
// Deframer back
// Ensemble store, byte parser with replay, descriptor emission and reads.
// ----------------------------------------------------------------------------
`default_nettype none

module vled_back #(
	parameter int BUF_BYTES = vled_pkg::DEF_BUF_BYTES,
	parameter int MAX_TYPES = vled_pkg::DEF_MAX_TYPES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  vled_pkg::vled_item_t q_item,
	output logic                 q_pop,
	vled_res_if.source           res
);
	import vled_pkg::*;

	localparam int AW   = $clog2(BUF_BYTES);
	localparam int CW   = $clog2(BUF_BYTES + 1);
	localparam int MAXN = (MAX_TYPES < MAX_DESC) ? MAX_TYPES : MAX_DESC;
	localparam int NW   = $clog2(MAXN + 1);
	localparam logic [16:0] BUF_W = 17'(BUF_BYTES);

	typedef enum logic [3:0] {
		S_IDLE,
		S_APPEND,
		S_FEED_RD,
		S_FEED_EX,
		S_CP_RD,
		S_CP_WR,
		S_EF_LO,
		S_EF_HI,
		S_EF_DN,
		S_EM_NEXT,
		S_EM_OUT,
		S_RD_ANS
	} state_t;

	// Ensemble store.
	logic [7:0]    mem [BUF_BYTES];
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    rd_data_q;

	state_t         state_q;
	vled_phase_t    phase_q;
	logic [CW-1:0]  fill_q;
	logic [CW-1:0]  rp_q;
	logic [CW-1:0]  pe_q;
	logic [15:0]    sum_q;
	logic [15:0]    len_q;
	logic [7:0]     len_lo_q;
	logic [7:0]     ck_lo_q;
	logic [7:0]     count_q;
	logic [7:0]     byte_q;
	logic           rd_zero_q;
	logic [CW-1:0]  cp_src_q;
	logic [CW-1:0]  cp_dst_q;
	logic [CW-1:0]  cp_cnt_q;
	logic           cp_ret_feed_q;
	logic [NW-1:0]  em_i_q;
	logic [NW-1:0]  em_n_q;
	logic [NW-1:0]  ef_k_q;
	logic           ef_nxt_q;
	logic [15:0]    cur_q;
	logic [15:0]    nxt_q;
	logic [7:0]     lo_q;

	logic           res_valid_q;
	logic           res_load;
	logic           kind_q;
	logic [3:0]     type_index_q;
	logic [10:0]    seg_start_q;
	logic [10:0]    seg_end_q;
	logic [7:0]     read_byte_q;
	logic           last_q;

	// Wide views for compares.
	logic [16:0]    fill_w;
	logic [16:0]    pe_w;
	logic [16:0]    len_w;
	logic [CW-1:0]  pend_n;
	logic [AW-1:0]  ent_pos;
	logic [16:0]    ent_pos_w;
	logic [15:0]    ent_raw;
	logic [15:0]    ent_val;
	logic           out_free;
	logic [NW-1:0]  n_types;

	// Parser step results.
	logic [CW-1:0]  fd_fill;
	vled_phase_t    fd_phase;
	logic [15:0]    fd_sum;
	logic [15:0]    fd_len;
	vled_feed_res_t fd_res;
	logic           fd_we;
	logic [AW-1:0]  fd_waddr;

	assign fill_w    = 17'(fill_q);
	assign pe_w      = 17'(pe_q);
	assign len_w     = 17'(len_q);
	assign pend_n    = pe_q - rp_q;
	assign ent_pos   = AW'(TABLE_BASE) + (AW'(ef_k_q) << 1);
	assign ent_pos_w = 17'(TABLE_BASE) + (17'(ef_k_q) << 1);
	assign ent_raw   = {rd_data_q, lo_q};
	assign out_free  = !res_valid_q || res.ready;
	assign res_load  = ((state_q == S_EM_OUT) || (state_q == S_RD_ANS)) && out_free;
	assign n_types   = (int'(count_q) > MAXN) ? NW'(MAXN) : NW'(count_q);

	always_comb begin
		if (ent_pos_w + 17'd1 >= len_w)
			ent_val = len_q;
		else if (ent_raw > len_q)
			ent_val = len_q;
		else
			ent_val = ent_raw;
	end

	// One parser step on the byte just read.
	always_comb begin
		fd_fill  = fill_q;
		fd_phase = phase_q;
		fd_sum   = sum_q;
		fd_len   = len_q;
		fd_res   = FD_MORE;
		fd_we    = 1'b0;
		fd_waddr = '0;
		case (phase_q)
			PH_HUNT: begin
				if (rd_data_q == SYNC_BYTE) begin
					fd_we    = 1'b1;
					fd_waddr = AW'(0);
					fd_fill  = CW'(1);
					fd_sum   = {8'd0, rd_data_q};
					fd_phase = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				if (rd_data_q == SYNC_BYTE) begin
					fd_we    = 1'b1;
					fd_waddr = AW'(1);
					fd_fill  = CW'(2);
					fd_sum   = sum_q + {8'd0, rd_data_q};
					fd_phase = PH_LEN;
				end else begin
					fd_fill  = '0;
					fd_sum   = '0;
					fd_phase = PH_HUNT;
				end
			end
			default: begin
				if (fill_w >= BUF_W) begin
					fd_res = FD_REJECT;
				end else begin
					fd_we    = 1'b1;
					fd_waddr = fill_q[AW-1:0];
					fd_fill  = fill_q + CW'(1);
					if (phase_q == PH_LEN) begin
						fd_sum = sum_q + {8'd0, rd_data_q};
						if (fill_w >= 17'd3) begin
							fd_len = {rd_data_q, len_lo_q};
							if (fd_len < MIN_LEN || 17'(fd_len) + 17'd2 > BUF_W)
								fd_res = FD_REJECT;
							else
								fd_phase = PH_BODY;
						end
					end else begin
						if (fill_w < len_w)
							fd_sum = sum_q + {8'd0, rd_data_q};
						if (fill_w + 17'd1 >= len_w + 17'd2) begin
							if ({rd_data_q, ck_lo_q} == fd_sum)
								fd_res = FD_ACCEPT;
							else
								fd_res = FD_REJECT;
						end
					end
				end
			end
		endcase
	end

	// Store port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = rd_data_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				mem_re    = q_valid && q_item.is_read;
				mem_raddr = AW'(q_item.read_offset);
			end
			S_APPEND: begin
				mem_we    = (pe_w < BUF_W);
				mem_waddr = pe_q[AW-1:0];
				mem_wdata = byte_q;
			end
			S_FEED_RD: begin
				mem_re    = (rp_q < pe_q);
				mem_raddr = rp_q[AW-1:0];
			end
			S_FEED_EX: begin
				mem_we    = fd_we;
				mem_waddr = fd_waddr;
			end
			S_CP_RD: begin
				mem_re    = (cp_cnt_q != '0);
				mem_raddr = cp_src_q[AW-1:0];
			end
			S_CP_WR: begin
				mem_we    = 1'b1;
				mem_waddr = cp_dst_q[AW-1:0];
			end
			S_EF_LO: begin
				mem_re    = 1'b1;
				mem_raddr = ent_pos;
			end
			S_EF_HI: begin
				mem_re    = 1'b1;
				mem_raddr = ent_pos + AW'(1);
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_data_q <= mem[mem_raddr];
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;

	assign res.valid      = res_valid_q;
	assign res.kind       = kind_q;
	assign res.type_index = type_index_q;
	assign res.seg_start  = seg_start_q;
	assign res.seg_end    = seg_end_q;
	assign res.read_byte  = read_byte_q;
	assign res.last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			phase_q       <= PH_HUNT;
			fill_q        <= '0;
			rp_q          <= '0;
			pe_q          <= '0;
			sum_q         <= '0;
			len_q         <= '0;
			cp_cnt_q      <= '0;
			cp_ret_feed_q <= 1'b0;
			em_i_q        <= '0;
			em_n_q        <= '0;
			ef_k_q        <= '0;
			ef_nxt_q      <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			// A new result loads the register; otherwise it empties once taken.
			res_valid_q <= res_load || (res_valid_q && !res.ready);
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_item.is_read) begin
							rd_zero_q <= !(17'(q_item.read_offset) < BUF_W);
							state_q   <= S_RD_ANS;
						end else begin
							byte_q <= q_item.rx_byte;
							if (rp_q >= pe_q) begin
								rp_q    <= fill_q;
								pe_q    <= fill_q;
								state_q <= S_APPEND;
							end else if (pe_w >= BUF_W) begin
								cp_src_q      <= rp_q;
								cp_dst_q      <= fill_q;
								cp_cnt_q      <= pend_n;
								cp_ret_feed_q <= 1'b0;
								rp_q          <= fill_q;
								pe_q          <= fill_q + pend_n;
								state_q       <= S_CP_RD;
							end else begin
								state_q <= S_APPEND;
							end
						end
					end
				end
				S_APPEND: begin
					if (pe_w < BUF_W)
						pe_q <= pe_q + CW'(1);
					state_q <= S_FEED_RD;
				end
				S_FEED_RD: begin
					if (rp_q < pe_q) begin
						rp_q    <= rp_q + CW'(1);
						state_q <= S_FEED_EX;
					end else begin
						rp_q    <= '0;
						pe_q    <= '0;
						state_q <= S_IDLE;
					end
				end
				S_FEED_EX: begin
					len_q <= fd_len;
					if (phase_q == PH_LEN && fill_w == 17'd2)
						len_lo_q <= rd_data_q;
					if (phase_q == PH_BODY && fill_w == len_w)
						ck_lo_q <= rd_data_q;
					if (phase_q == PH_BODY && fill_w == 17'(COUNT_POS))
						count_q <= rd_data_q;
					case (fd_res)
						FD_ACCEPT: begin
							fill_q  <= '0;
							phase_q <= PH_HUNT;
							sum_q   <= '0;
							if (rp_q >= pe_q) begin
								rp_q <= '0;
								pe_q <= '0;
							end
							em_i_q   <= '0;
							em_n_q   <= n_types;
							ef_k_q   <= '0;
							ef_nxt_q <= 1'b0;
							if (n_types == '0)
								state_q <= S_IDLE;
							else
								state_q <= S_EF_LO;
						end
						FD_REJECT: begin
							// Move the unread bytes down behind the candidate and
							// rescan from its second byte.
							cp_src_q      <= rp_q;
							cp_dst_q      <= fd_fill;
							cp_cnt_q      <= pend_n;
							cp_ret_feed_q <= 1'b1;
							pe_q          <= fd_fill + pend_n;
							rp_q          <= CW'(1);
							fill_q        <= '0;
							phase_q       <= PH_HUNT;
							sum_q         <= '0;
							state_q       <= S_CP_RD;
						end
						default: begin
							fill_q  <= fd_fill;
							phase_q <= fd_phase;
							sum_q   <= fd_sum;
							state_q <= S_FEED_RD;
						end
					endcase
				end
				S_CP_RD: begin
					if (cp_cnt_q == '0) begin
						state_q <= cp_ret_feed_q ? S_FEED_RD : S_APPEND;
					end else begin
						cp_src_q <= cp_src_q + CW'(1);
						state_q  <= S_CP_WR;
					end
				end
				S_CP_WR: begin
					cp_dst_q <= cp_dst_q + CW'(1);
					cp_cnt_q <= cp_cnt_q - CW'(1);
					state_q  <= S_CP_RD;
				end
				S_EF_LO: begin
					state_q <= S_EF_HI;
				end
				S_EF_HI: begin
					lo_q    <= rd_data_q;
					state_q <= S_EF_DN;
				end
				S_EF_DN: begin
					if (ef_nxt_q) begin
						nxt_q   <= ent_val;
						state_q <= S_EM_OUT;
					end else begin
						cur_q   <= ent_val;
						state_q <= S_EM_NEXT;
					end
				end
				S_EM_NEXT: begin
					if (int'(em_i_q) + 1 < int'(count_q)) begin
						ef_k_q   <= em_i_q + NW'(1);
						ef_nxt_q <= 1'b1;
						state_q  <= S_EF_LO;
					end else begin
						nxt_q   <= len_q;
						state_q <= S_EM_OUT;
					end
				end
				S_EM_OUT: begin
					if (out_free) begin
						kind_q       <= KIND_DESC;
						type_index_q <= 4'(em_i_q);
						seg_start_q  <= cur_q[10:0];
						seg_end_q    <= (nxt_q < cur_q) ? cur_q[10:0] : nxt_q[10:0];
						read_byte_q  <= 8'd0;
						last_q       <= (em_i_q + NW'(1) == em_n_q);
						em_i_q       <= em_i_q + NW'(1);
						cur_q        <= nxt_q;
						if (em_i_q + NW'(1) == em_n_q)
							state_q <= S_IDLE;
						else
							state_q <= S_EM_NEXT;
					end
				end
				S_RD_ANS: begin
					if (out_free) begin
						kind_q       <= KIND_READ;
						type_index_q <= 4'd0;
						seg_start_q  <= 11'd0;
						seg_end_q    <= 11'd0;
						read_byte_q  <= rd_zero_q ? 8'd0 : rd_data_q;
						last_q       <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
